// ===== design/homogeneous_point_transform_macros.svh =====
// Assertion macros shared by the transform pipeline.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define HPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hpt_pkg.sv =====
// Shared constants, types and helpers of the homogeneous point transform.
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SHR_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SHR_W + 2;
  localparam int QUO_W     = COORD_W - 1;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 2 * COORD_W;

  localparam logic [COORD_W-1:0] FX_ONE = COORD_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0]   W_ONE  = SUM_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] DIAG_LO = {{COORD_W{1'b0}}, FX_ONE};
  localparam logic [CFG_W-1:0] DIAG_HI = {FX_ONE, {COORD_W{1'b0}}};

  typedef struct packed {
    logic                          direct;
    logic                          wz;
    logic [2:0]                    ovf;
    logic [2:0]                    neg;
    logic [2:0][COORD_W-1:0]       dval;
  } sb_t;

  function automatic logic [COORD_W-1:0] sat32(input logic [SUM_W-1:0] v);
    logic hi_same;
    hi_same = (v[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){1'b0}}) ||
              (v[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){1'b1}});
    if (hi_same) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

// ===== design/hpt_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps
module hpt_div import hpt_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] p_in,
  input  logic [SUM_W-1:0] d_in,
  input  logic [QUO_W-1:0] n_in,
  output logic [QUO_W-1:0] q_out
);

  logic [SUM_W-1:0] p_r   [QUO_W];
  logic [SUM_W-1:0] d_r   [QUO_W];
  logic [QUO_W-1:0] sh_r  [QUO_W];
  logic [SUM_W-1:0] p_nxt [QUO_W];
  logic [SUM_W-1:0] d_nxt [QUO_W];
  logic [QUO_W-1:0] sh_nxt[QUO_W];
  logic [SUM_W-1:0] p_src [QUO_W];
  logic [SUM_W-1:0] d_src [QUO_W];
  logic [QUO_W-1:0] sh_src[QUO_W];

  always_comb begin
    p_src[0]  = p_in;
    d_src[0]  = d_in;
    sh_src[0] = n_in;
    for (int i = 1; i < QUO_W; i++) begin
      p_src[i]  = p_r[i-1];
      d_src[i]  = d_r[i-1];
      sh_src[i] = sh_r[i-1];
    end
  end

  // shift the next dividend bit into the partial remainder, take the quotient bit out
  always_comb begin
    logic [SUM_W:0] trial;
    logic           ge;
    for (int i = 0; i < QUO_W; i++) begin
      trial     = {p_src[i], sh_src[i][QUO_W-1]};
      ge        = (trial >= {1'b0, d_src[i]});
      p_nxt[i]  = ge ? SUM_W'(trial - {1'b0, d_src[i]}) : SUM_W'(trial);
      d_nxt[i]  = d_src[i];
      sh_nxt[i] = {sh_src[i][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QUO_W; i++) begin
        p_r[i]  <= p_nxt[i];
        d_r[i]  <= d_nxt[i];
        sh_r[i] <= sh_nxt[i];
      end
    end
  end

  assign q_out = sh_r[QUO_W-1];

endmodule

// ===== design/homogeneous_point_transform.sv =====
// Homogeneous 4x4 point/vector transform with perspective divide, signed Q16.16.
// Takes one item per clock and delivers one result per clock when the output side
// does not stall. Each item passes the product register (the twelve 32x32
// multiplies), the row-sum register, the divide set-up register, the stages of the
// bit-per-stage divider and the output register; out_valid rises together with
// the output register.
// A stall with out_valid high freezes the whole pipeline, fed back as in_stall.
// The matrix registers reset to identity and should be written only while idle.
`timescale 1ns / 1ps
`include "homogeneous_point_transform_macros.svh"
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [COORD_W-1:0]   in_x,
  input  logic [COORD_W-1:0]   in_y,
  input  logic [COORD_W-1:0]   in_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic [COORD_W-1:0]   out_z,
  output logic                 out_w_zero,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] m_r [NUM_REGS];
  logic [3:0][3:0][COORD_W-1:0] el;

  logic en;
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic [QUO_W-1:0] vd_r;

  logic                   op1_r, op2_r;
  logic [3:0][2:0][PROD_W-1:0] prod_r;
  logic [3:0][SUM_W-1:0]  sum_r;
  logic [3:0][SUM_W-1:0]  sum_nxt;

  sb_t              sb_nxt;
  sb_t              sb_r [QUO_W+1];
  logic [2:0][SUM_W-1:0] p0_nxt, dd_nxt;
  logic [2:0][QUO_W-1:0] nb_nxt;
  logic [2:0][SUM_W-1:0] p0_r, dd_r;
  logic [2:0][QUO_W-1:0] nb_r;
  logic [2:0][QUO_W-1:0] q;

  logic [2:0][COORD_W-1:0] res_nxt;
  logic [2:0][COORD_W-1:0] res_r;
  logic                    wz_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if ((i == 0) || (i == 5)) begin
          m_r[i] <= DIAG_LO;
        end else if ((i == 2) || (i == 7)) begin
          m_r[i] <= DIAG_HI;
        end else begin
          m_r[i] <= '0;
        end
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      m_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      el[r][0] = m_r[2*r][COORD_W-1:0];
      el[r][1] = m_r[2*r][CFG_W-1:COORD_W];
      el[r][2] = m_r[2*r+1][COORD_W-1:0];
      el[r][3] = m_r[2*r+1][CFG_W-1:COORD_W];
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_op;
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= PROD_W'($signed(in_x) * $signed(el[r][0]));
        prod_r[r][1] <= PROD_W'($signed(in_y) * $signed(el[r][1]));
        prod_r[r][2] <= PROD_W'($signed(in_z) * $signed(el[r][2]));
      end
    end
  end

  // stage 2: floor-shifted products plus translation (points only)
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = SUM_W'($signed(prod_r[r][0][PROD_W-1:FRAC_BITS]))
                 + SUM_W'($signed(prod_r[r][1][PROD_W-1:FRAC_BITS]))
                 + SUM_W'($signed(prod_r[r][2][PROD_W-1:FRAC_BITS]))
                 + (op1_r ? '0 : SUM_W'($signed(el[r][3])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      sum_r <= sum_nxt;
    end
  end

  // stage 3: magnitudes, signs, overflow test and the no-divide results
  always_comb begin
    logic [SUM_W-1:0]          n;
    logic [SUM_W-1:0]          d;
    logic [SUM_W+FRAC_BITS-1:0] nn;
    d = sum_r[3][SUM_W-1] ? SUM_W'(-sum_r[3]) : sum_r[3];
    sb_nxt.direct = op2_r || (sum_r[3] == W_ONE);
    sb_nxt.wz     = !op2_r && (sum_r[3] == '0);
    for (int c = 0; c < 3; c++) begin
      n  = sum_r[c][SUM_W-1] ? SUM_W'(-sum_r[c]) : sum_r[c];
      nn = {n, {FRAC_BITS{1'b0}}};
      sb_nxt.neg[c]  = sum_r[c][SUM_W-1] ^ sum_r[3][SUM_W-1];
      sb_nxt.dval[c] = sat32(sum_r[c]);
      p0_nxt[c]      = SUM_W'(nn >> QUO_W);
      nb_nxt[c]      = nn[QUO_W-1:0];
      dd_nxt[c]      = d;
      sb_nxt.ovf[c]  = (SUM_W'(nn >> QUO_W) >= d);
    end
  end

  // side band starts level with the divider input register and ends level with q
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      nb_r <= nb_nxt;
      dd_r <= dd_nxt;
      sb_r[0] <= sb_nxt;
      for (int i = 1; i <= QUO_W; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    hpt_div u_div (
      .clk   (clk),
      .en    (en),
      .p_in  (p0_r[c]),
      .d_in  (dd_r[c]),
      .n_in  (nb_r[c]),
      .q_out (q[c])
    );
  end

  // output select
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (sb_r[QUO_W].wz) begin
        res_nxt[c] = '0;
      end else if (sb_r[QUO_W].direct) begin
        res_nxt[c] = sb_r[QUO_W].dval[c];
      end else if (sb_r[QUO_W].ovf[c]) begin
        res_nxt[c] = sb_r[QUO_W].neg[c] ? SAT_MIN : SAT_MAX;
      end else if (sb_r[QUO_W].neg[c]) begin
        res_nxt[c] = COORD_W'(-{1'b0, q[c]});
      end else begin
        res_nxt[c] = {1'b0, q[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      wz_r  <= sb_r[QUO_W].wz;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      vd_r        <= {vd_r[QUO_W-2:0], v3_r};
      out_valid_r <= vd_r[QUO_W-1];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = res_r[0];
  assign out_y      = res_r[1];
  assign out_z      = res_r[2];
  assign out_w_zero = wz_r;

  `HPT_ASSERT_IMPL(a_wz_zero, out_valid_r && wz_r, res_r == '0, "w_zero result is not zero")
  `HPT_ASSERT_NEXT(a_last_to_out, vd_r[QUO_W-1] && en, out_valid_r, "divider output lost")
  `HPT_ASSERT_IMPL(a_wz_not_direct, vd_r[QUO_W-1] && sb_r[QUO_W].wz,
                   !sb_r[QUO_W].direct, "zero w flagged on direct path")
  `HPT_ASSERT_NEXT(a_freeze, !en, $stable(vd_r) && $stable(v3_r), "pipeline moved during stall")

endmodule
